### hdl/iso2e_pkg.sv
package iso2e_pkg;

    localparam int F_DATE = 0;
    localparam int F_TSEP = 1;
    localparam int F_HH   = 2;
    localparam int F_MI   = 3;
    localparam int F_SCOL = 4;
    localparam int F_SS   = 5;

    localparam logic [5:0] FLAGS_ALL = 6'h3F;
    localparam logic [4:0] POS_SAT   = 5'd19;

    localparam logic [4:0] LEN_DATE = 5'd10;
    localparam logic [4:0] LEN_HHMM = 5'd16;
    localparam logic [4:0] LEN_SECS = 5'd19;

    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [5:0]  flags;
        logic [4:0]  len;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DATE,
        B_MUL,
        B_SUM,
        B_OUT
    } t_bstate;

endpackage

### hdl/iso2e_front.sv
module iso2e_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_beat,
    input  logic [7:0]       i_char,
    input  logic             i_last,
    output iso2e_pkg::t_rec  o_rec,
    output logic             o_push
);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3A;

    logic [4:0]  r_pos;
    logic [13:0] r_year, n_year;
    logic [6:0]  r_month, n_month;
    logic [6:0]  r_day, n_day;
    logic [6:0]  r_hour, n_hour;
    logic [6:0]  r_minute, n_minute;
    logic [6:0]  r_second, n_second;
    logic [5:0]  r_flags, n_flags;
    logic        is_dig;
    logic [3:0]  dig;

    always_comb begin
        is_dig   = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        dig      = is_dig ? 4'(i_char - CH_ZERO) : 4'd0;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_flags  = r_flags;
        case (r_pos)
            5'd0, 5'd1, 5'd2, 5'd3: begin
                if (!is_dig) n_flags[iso2e_pkg::F_DATE] = 1'b0;
                n_year = 14'(r_year * 14'd10 + 14'(dig));
            end
            5'd4, 5'd7: begin
                if (i_char != CH_DASH) n_flags[iso2e_pkg::F_DATE] = 1'b0;
            end
            5'd5, 5'd6: begin
                if (!is_dig) n_flags[iso2e_pkg::F_DATE] = 1'b0;
                n_month = 7'(r_month * 7'd10 + 7'(dig));
            end
            5'd8, 5'd9: begin
                if (!is_dig) n_flags[iso2e_pkg::F_DATE] = 1'b0;
                n_day = 7'(r_day * 7'd10 + 7'(dig));
            end
            5'd10: begin
                if (i_char != CH_T) n_flags[iso2e_pkg::F_TSEP] = 1'b0;
            end
            5'd11, 5'd12: begin
                if (!is_dig) n_flags[iso2e_pkg::F_HH] = 1'b0;
                n_hour = 7'(r_hour * 7'd10 + 7'(dig));
            end
            5'd13: begin
                if (i_char != CH_COLON) n_flags[iso2e_pkg::F_TSEP] = 1'b0;
            end
            5'd14, 5'd15: begin
                if (!is_dig) n_flags[iso2e_pkg::F_MI] = 1'b0;
                n_minute = 7'(r_minute * 7'd10 + 7'(dig));
            end
            5'd16: begin
                if (i_char != CH_COLON) n_flags[iso2e_pkg::F_SCOL] = 1'b0;
            end
            5'd17, 5'd18: begin
                if (!is_dig) n_flags[iso2e_pkg::F_SS] = 1'b0;
                n_second = 7'(r_second * 7'd10 + 7'(dig));
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_push        = i_beat && i_last;
        o_rec.year    = n_year;
        o_rec.month   = n_month;
        o_rec.day     = n_day;
        o_rec.hour    = n_hour;
        o_rec.minute  = n_minute;
        o_rec.second  = n_second;
        o_rec.flags   = n_flags;
        o_rec.len     = 5'(r_pos + 5'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_beat && i_last)) begin
            r_pos    <= 5'd0;
            r_year   <= 14'd0;
            r_month  <= 7'd0;
            r_day    <= 7'd0;
            r_hour   <= 7'd0;
            r_minute <= 7'd0;
            r_second <= 7'd0;
            r_flags  <= iso2e_pkg::FLAGS_ALL;
        end else if (i_beat) begin
            r_pos    <= (r_pos < iso2e_pkg::POS_SAT) ? 5'(r_pos + 5'd1) : iso2e_pkg::POS_SAT;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_flags  <= n_flags;
        end
    end

endmodule

### hdl/iso2e_fifo.sv
module iso2e_fifo #(
    parameter int P_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  iso2e_pkg::t_rec   i_rec,
    input  logic              i_pop,
    output iso2e_pkg::t_rec   o_rec,
    output iso2e_pkg::t_qstat o_stat
);

    localparam int AW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    iso2e_pkg::t_rec r_mem [P_DEPTH];
    iso2e_pkg::t_rec r_head;
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    always_comb begin
        o_stat.full  = (r_count == CW'(P_DEPTH));
        o_stat.empty = (r_count == CW'(0));
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && !o_stat.empty;
        o_rec        = r_head;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
        if (do_pop) begin
            r_head <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(P_DEPTH - 1)) ? '0 : AW'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(P_DEPTH - 1)) ? '0 : AW'(r_rd + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

endmodule

### hdl/iso2e_back.sv
module iso2e_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iso2e_pkg::t_rec   i_rec,
    input  iso2e_pkg::t_qstat i_stat,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [39:0]       o_tdata,
    output logic              o_tuser
);

    localparam logic [23:0] DAYS_BIAS = 24'd865565;
    localparam logic [26:0] RECIP_100 = 27'd5243;

    iso2e_pkg::t_bstate r_state, n_state;

    logic        r_ok, n_ok;
    logic        r_addt, n_addt;
    logic        r_usesec, n_usesec;
    logic [13:0] r_y, n_y;
    logic [8:0]  r_doy, n_doy;
    logic [21:0] r_ymul;
    logic [7:0]  r_q100;
    logic [18:0] r_tod;
    logic [22:0] r_days;
    logic [23:0] n_days;
    logic [26:0] q_prod;
    logic [38:0] n_secs;
    logic        r_ovalid;
    logic [38:0] r_odata;
    logic        r_ouser;
    logic        ld_out;

    function automatic logic [8:0] month_start(input logic [6:0] m);
        logic [8:0] v;
        case (m)
            7'd3:    v = 9'd0;
            7'd4:    v = 9'd31;
            7'd5:    v = 9'd61;
            7'd6:    v = 9'd92;
            7'd7:    v = 9'd122;
            7'd8:    v = 9'd153;
            7'd9:    v = 9'd184;
            7'd10:   v = 9'd214;
            7'd11:   v = 9'd245;
            7'd12:   v = 9'd275;
            7'd1:    v = 9'd306;
            7'd2:    v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            iso2e_pkg::B_IDLE: begin
                if (!i_stat.empty) n_state = iso2e_pkg::B_DATE;
            end
            iso2e_pkg::B_DATE: n_state = iso2e_pkg::B_MUL;
            iso2e_pkg::B_MUL:  n_state = iso2e_pkg::B_SUM;
            iso2e_pkg::B_SUM:  n_state = iso2e_pkg::B_OUT;
            iso2e_pkg::B_OUT: begin
                if (!r_ovalid || i_tready) n_state = iso2e_pkg::B_IDLE;
            end
            default: n_state = iso2e_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        ld_out = 1'b0;
        case (r_state)
            iso2e_pkg::B_IDLE: o_pop = !i_stat.empty;
            iso2e_pkg::B_OUT:  ld_out = !r_ovalid || i_tready;
            default: begin
            end
        endcase
    end

    always_comb begin
        n_ok = (i_rec.len >= iso2e_pkg::LEN_DATE) && i_rec.flags[iso2e_pkg::F_DATE] &&
               (i_rec.month >= 7'd1) && (i_rec.month <= 7'd12) &&
               (i_rec.day >= 7'd1) && (i_rec.day <= 7'd31);
        n_usesec = (i_rec.len >= iso2e_pkg::LEN_SECS) && i_rec.flags[iso2e_pkg::F_SCOL];
        n_addt = (i_rec.len >= iso2e_pkg::LEN_HHMM) && i_rec.flags[iso2e_pkg::F_TSEP] &&
                 i_rec.flags[iso2e_pkg::F_HH] && i_rec.flags[iso2e_pkg::F_MI] &&
                 (!n_usesec || i_rec.flags[iso2e_pkg::F_SS]);
        n_y = 14'(i_rec.year + 14'd400 - ((i_rec.month <= 7'd2) ? 14'd1 : 14'd0));
        n_doy = 9'(month_start(i_rec.month) + 9'(i_rec.day) - 9'd1);
        q_prod = 27'(r_y) * RECIP_100;
        n_days = 24'(r_ymul) + 24'(r_y[13:2]) - 24'(r_q100) + 24'(r_q100[7:2]) +
                 24'(r_doy) - DAYS_BIAS;
        n_secs = 39'({{16{r_days[22]}}, r_days} * 39'd86400) +
                 (r_addt ? 39'(r_tod) : 39'd0);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == iso2e_pkg::B_DATE) begin
            r_ok     <= n_ok;
            r_addt   <= n_addt;
            r_usesec <= n_usesec;
            r_y      <= n_y;
            r_doy    <= n_doy;
        end
        if (r_state == iso2e_pkg::B_MUL) begin
            r_ymul <= 22'(r_y * 22'd365);
            r_q100 <= q_prod[26:19];
            r_tod  <= 19'(19'(i_rec.hour) * 19'd3600 + 19'(i_rec.minute) * 19'd60 +
                          (r_usesec ? 19'(i_rec.second) : 19'd0));
        end
        if (r_state == iso2e_pkg::B_SUM) begin
            r_days <= n_days[22:0];
        end
        if (ld_out) begin
            r_odata <= r_ok ? n_secs : 39'd0;
            r_ouser <= r_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= iso2e_pkg::B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ld_out) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = {1'b0, r_odata};
    assign o_tuser  = r_ouser;

endmodule

### hdl/iso_datetime_to_epoch_seconds_core.sv
// Converts an ISO-8601 date string, given one character per beat with tlast on the final
// character, into signed UTC epoch seconds and a flag that says whether the string was a date.
// The front accepts one character every cycle while the queue is not full, and hands each
// finished string to a queue of P_QUEUE_DEPTH entries; the back sequencer converts one string
// at a time through queue pop, date decode, multiply, day sum and seconds multiply into the
// output register. Long strings therefore stream at one character per cycle, while a run of
// shorter strings is paced by the back sequencer once the queue has filled.
module iso_datetime_to_epoch_seconds_core #(
    parameter int P_QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [38:0] epoch_seconds, [39] zero
    output logic        m_axis_tuser    // valid_res
);

    iso2e_pkg::t_rec   w_front_rec;
    iso2e_pkg::t_rec   w_head_rec;
    iso2e_pkg::t_qstat w_stat;
    logic              w_push;
    logic              w_pop;
    logic              w_beat;

    assign s_axis_tready = !w_stat.full;
    assign w_beat        = s_axis_tvalid && s_axis_tready;

    iso2e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_beat),
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_rec   (w_front_rec),
        .o_push  (w_push)
    );

    iso2e_fifo #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_front_rec),
        .i_pop   (w_pop),
        .o_rec   (w_head_rec),
        .o_stat  (w_stat)
    );

    iso2e_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rec    (w_head_rec),
        .i_stat   (w_stat),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 40'd0))
        else $error("Invalid result carries nonzero seconds.");

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.full && w_stat.empty))
        else $error("Queue reports full and empty at once.");

    a_range_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        ($signed(m_axis_tdata[38:0]) >= -39'sd62167219200))
        else $error("Valid result lies before year zero.");

endmodule
